// File: rtl/snsm_pkg.sv
// ----------------------------------------------------------------------------
// snsm_pkg: shared types, constants and functions
// SHA-1 round constants, initial values, message schedule and round helpers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package snsm_pkg;

   localparam int unsigned NumRounds = 80;
   localparam int unsigned CsrIdxW   = 3;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_MSG_01 = 3'd0,
      CSR_MSG_23 = 3'd1,
      CSR_MSG_45 = 3'd2,
      CSR_MSG_67 = 3'd3,
      CSR_TGT_01 = 3'd4,
      CSR_TGT_23 = 3'd5,
      CSR_TGT_4  = 3'd6,
      CSR_DIFF   = 3'd7
   } csr_idx_type;

   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;
   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hEFCDAB89;
   localparam logic [31:0] IV2 = 32'h98BADCFE;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] IV4 = 32'hC3D2E1F0;
   localparam logic [31:0] PadWord = 32'h80000000;
   localparam logic [31:0] LenWord = 32'h00000100;
   localparam logic [7:0]  FullMatch = 8'd160;

   typedef struct packed {
      logic [63:0] nonce;
      logic [63:0] tag;
      logic [31:0] w6;
      logic [31:0] w7;
   } job_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic [31:0] e;
   } state_type;

   function automatic logic [31:0] rol1(input logic [31:0] v);
      rol1 = {v[30:0], v[31]};
   endfunction

   // one compression round
   function automatic state_type sha_round(input state_type s, input logic [31:0] w,
                                          input int unsigned t);
      logic [31:0] f;
      logic [31:0] k;
      state_type   o;
      if (t < 20) begin
         f = (s.b & s.c) | (~s.b & s.d);
         k = K0;
      end else if (t < 40) begin
         f = s.b ^ s.c ^ s.d;
         k = K1;
      end else if (t < 60) begin
         f = (s.b & s.c) | (s.b & s.d) | (s.c & s.d);
         k = K2;
      end else begin
         f = s.b ^ s.c ^ s.d;
         k = K3;
      end
      o.a = {s.a[26:0], s.a[31:27]} + f + s.e + k + w;
      o.b = s.a;
      o.c = {s.b[1:0], s.b[31:2]};
      o.d = s.c;
      o.e = s.d;
      sha_round = o;
   endfunction

   function automatic logic [5:0] lead_zero32(input logic [31:0] v);
      logic [5:0] n;
      logic       hit;
      n = 6'd32;
      hit = 1'b0;
      for (int i = 31; i >= 0; i--) begin
         if (v[i] && !hit) begin
            n = 6'(31 - i);
            hit = 1'b1;
         end
      end
      lead_zero32 = n;
   endfunction

endpackage

// File: rtl/snsm_front.sv
// ----------------------------------------------------------------------------
// snsm_front: request intake
// Drops zero nonces, forms message words 6 and 7 and registers the job
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module snsm_front import snsm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] req_nonce,
   input  logic [63:0] req_job_tag,
   input  logic [63:0] msg_67,
   output logic        job_valid,
   output job_type     job
);
   logic    valid_ff, valid_in;
   job_type job_ff, job_in;

   always_comb begin
      valid_in  = start && (req_nonce != 64'd0);
      job_in.nonce = req_nonce;
      job_in.tag   = req_job_tag;
      job_in.w6    = msg_67[63:32] ^ req_nonce[63:32];
      job_in.w7    = msg_67[31:0] ^ req_nonce[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      job_ff <= job_in;
   end

   assign job_valid = valid_ff;
   assign job       = job_ff;
endmodule

// File: rtl/snsm_back.sv
// ----------------------------------------------------------------------------
// snsm_back: unrolled sha-1 pipeline and match check
// One round per stage, with the schedule window carried alongside
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module snsm_back import snsm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         job_valid,
   input  job_type      job,
   input  logic [191:0] msg_base,
   input  logic [159:0] target,
   input  logic [7:0]   difficulty,
   output logic         rsp_valid,
   output logic [63:0]  rsp_found_nonce,
   output logic [7:0]   rsp_match_count,
   output logic [31:0]  rsp_digest_word_0,
   output logic [31:0]  rsp_digest_word_1,
   output logic [31:0]  rsp_digest_word_2,
   output logic [31:0]  rsp_digest_word_3,
   output logic [31:0]  rsp_digest_word_4,
   output logic [63:0]  rsp_result_tag
);
   // stage t holds state after t rounds and schedule words w[t..t+15]
   logic          vld_ff [NumRounds+1];
   state_type     st_ff  [NumRounds+1];
   logic [511:0]  win_ff [NumRounds+1];
   logic [63:0]   non_ff [NumRounds+1];
   logic [63:0]   tag_ff [NumRounds+1];

   logic [511:0] win0;
   always_comb begin
      win0 = {LenWord, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, PadWord,
              job.w7, job.w6, msg_base[31:0], msg_base[63:32], msg_base[95:64],
              msg_base[127:96], msg_base[159:128], msg_base[191:160]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= job_valid;
      end
      st_ff[0]  <= '{a: IV0, b: IV1, c: IV2, d: IV3, e: IV4};
      win_ff[0] <= win0;
      non_ff[0] <= job.nonce;
      tag_ff[0] <= job.tag;
   end

   for (genvar t = 0; t < NumRounds; t++) begin : g_round
      logic [31:0]  w_new;
      assign w_new = rol1(win_ff[t][13*32 +: 32] ^ win_ff[t][8*32 +: 32] ^
                          win_ff[t][2*32 +: 32] ^ win_ff[t][31:0]);
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[t+1] <= 1'b0;
         end else begin
            vld_ff[t+1] <= vld_ff[t];
         end
         st_ff[t+1]  <= sha_round(st_ff[t], win_ff[t][31:0], t);
         win_ff[t+1] <= {w_new, win_ff[t][511:32]};
         non_ff[t+1] <= non_ff[t];
         tag_ff[t+1] <= tag_ff[t];
      end
   end

   // final add and target compare
   logic [159:0] dig_ff, dig_in, x;
   logic         dvld_ff;
   logic [63:0]  dnon_ff, dtag_ff;
   state_type    s;
   assign s = st_ff[NumRounds];
   assign dig_in = {s.a + IV0, s.b + IV1, s.c + IV2, s.d + IV3, s.e + IV4};

   always_ff @(posedge clock) begin
      if (reset) begin
         dvld_ff <= 1'b0;
      end else begin
         dvld_ff <= vld_ff[NumRounds];
      end
      dig_ff  <= dig_in;
      dnon_ff <= non_ff[NumRounds];
      dtag_ff <= tag_ff[NumRounds];
   end

   logic [7:0] cnt;
   logic       done;
   assign x = dig_ff ^ target;
   always_comb begin
      cnt  = FullMatch;
      done = 1'b0;
      for (int i = 0; i < 5; i++) begin
         if (!done && x[(4-i)*32 +: 32] != 32'd0) begin
            cnt  = 8'(i * 32) + {2'b0, lead_zero32(x[(4-i)*32 +: 32])};
            done = 1'b1;
         end
      end
   end

   logic         ov_ff, ov_in;
   logic [7:0]   ocnt_ff;
   logic [159:0] odig_ff;
   logic [63:0]  onon_ff, otag_ff;
   assign ov_in = dvld_ff && (cnt >= difficulty);

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= ov_in;
      end
      ocnt_ff <= cnt;
      odig_ff <= dig_ff;
      onon_ff <= dnon_ff;
      otag_ff <= dtag_ff;
   end

   assign rsp_valid         = ov_ff;
   assign rsp_found_nonce   = onon_ff;
   assign rsp_match_count   = ocnt_ff;
   assign rsp_digest_word_0 = odig_ff[159:128];
   assign rsp_digest_word_1 = odig_ff[127:96];
   assign rsp_digest_word_2 = odig_ff[95:64];
   assign rsp_digest_word_3 = odig_ff[63:32];
   assign rsp_digest_word_4 = odig_ff[31:0];
   assign rsp_result_tag    = otag_ff;
endmodule

// File: rtl/sha1_nonce_search_match.sv
// ----------------------------------------------------------------------------
// sha1_nonce_search_match: sha-1 proof-of-work nonce checker
// Hashes one nonce per cycle and reports digests that meet the difficulty
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_nonce, req_job_tag) is taken at every clock edge where
//   start is high; busy is always low, so one request enters each cycle.
//   The front registers the request and drops zero nonces; the back runs an
//   80-stage unrolled round pipeline, adds the initial values, counts the
//   leading bits that match the target and registers the result.
//   Each request passes through the front register, the input stage, the round
//   stages, the digest register and the output register; throughput is one
//   request per cycle, set by the one-round-per-stage pipeline.
//   A qualifying result shows for exactly one cycle with rsp_valid high and
//   the receiver cannot hold it off; requests that miss the difficulty give
//   no strobe.
//   csr_* writes registers by index; write them only while no request is in
//   flight. Synchronous reset clears CSRs and valid bits, emptying the pipe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sha1_nonce_search_match import snsm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [63:0]        req_nonce,
   input  logic [63:0]        req_job_tag,
   input  logic               csr_write_enable,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [63:0]        csr_write_data,
   output logic               rsp_valid,
   output logic [63:0]        rsp_found_nonce,
   output logic [7:0]         rsp_match_count,
   output logic [31:0]        rsp_digest_word_0,
   output logic [31:0]        rsp_digest_word_1,
   output logic [31:0]        rsp_digest_word_2,
   output logic [31:0]        rsp_digest_word_3,
   output logic [31:0]        rsp_digest_word_4,
   output logic [63:0]        rsp_result_tag
);
   logic [63:0] msg01_ff, msg23_ff, msg45_ff, msg67_ff, tgt01_ff, tgt23_ff;
   logic [31:0] tgt4_ff;
   logic [7:0]  diff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         msg01_ff <= '0;
         msg23_ff <= '0;
         msg45_ff <= '0;
         msg67_ff <= '0;
         tgt01_ff <= '0;
         tgt23_ff <= '0;
         tgt4_ff  <= '0;
         diff_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MSG_01: msg01_ff <= csr_write_data;
            CSR_MSG_23: msg23_ff <= csr_write_data;
            CSR_MSG_45: msg45_ff <= csr_write_data;
            CSR_MSG_67: msg67_ff <= csr_write_data;
            CSR_TGT_01: tgt01_ff <= csr_write_data;
            CSR_TGT_23: tgt23_ff <= csr_write_data;
            CSR_TGT_4:  tgt4_ff  <= csr_write_data[31:0];
            CSR_DIFF:   diff_ff  <= csr_write_data[7:0];
            default:    ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic    job_valid;
   job_type job;

   snsm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_nonce   (req_nonce),
      .req_job_tag (req_job_tag),
      .msg_67      (msg67_ff),
      .job_valid   (job_valid),
      .job         (job)
   );

   snsm_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (job_valid),
      .job               (job),
      .msg_base          ({msg01_ff, msg23_ff, msg45_ff}),
      .target            ({tgt01_ff, tgt23_ff, tgt4_ff}),
      .difficulty        (diff_ff),
      .rsp_valid         (rsp_valid),
      .rsp_found_nonce   (rsp_found_nonce),
      .rsp_match_count   (rsp_match_count),
      .rsp_digest_word_0 (rsp_digest_word_0),
      .rsp_digest_word_1 (rsp_digest_word_1),
      .rsp_digest_word_2 (rsp_digest_word_2),
      .rsp_digest_word_3 (rsp_digest_word_3),
      .rsp_digest_word_4 (rsp_digest_word_4),
      .rsp_result_tag    (rsp_result_tag)
   );
endmodule
